FILE: rtl/sius_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sius_pkg
// Shared types and codes for the sorted interval union set unit.
// ----------------------------------------------------------------------------
package sius_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic resolve;
    logic copy;
    logic place;
    logic finish;
  } sius_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;
    logic is_query;
    logic found;
    logic full;
    logic scan_done;
    logic copy_done;
  } sius_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sorted_interval_union_set_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_interval_union_set_unit
// Sorted set of disjoint closed intervals with add/merge, point query, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_operation and the coordinate ports and raise
//   start; the request is taken on a clock edge where start is high and busy
//   is low. busy stays high until the result has been produced.
//   Result channel: out_valid pulses for one cycle with out_status,
//   out_covered and out_interval_count. The receiver cannot stall it.
//   Clear, an unused code and an inverted add range go straight to the
//   result. A query scans the entries; an add scans, then shifts the
//   entries up or compacts them, unless the set is full and the request
//   overlaps no entry.
//   Entries live in a RAM with one read and one write port; scan and
//   shift or compaction each move one entry per cycle.
//   A new request may be given in the cycle the result is shown.
//   Reset (rst_n low, synchronous) empties the set; entry contents are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_interval_union_set_unit #(
  parameter int MAX_INTERVALS = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sius_pkg::OP_W-1:0]     in_operation,
  input  wire logic signed [COORD_WIDTH-1:0] in_interval_low,
  input  wire logic signed [COORD_WIDTH-1:0] in_interval_high,
  input  wire logic signed [COORD_WIDTH-1:0] in_point,
  output logic                               out_valid,
  output logic [sius_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_covered,
  output logic [sius_pkg::COUNT_W-1:0]       out_interval_count
);
  import sius_pkg::*;

  sius_cmd_t  cmd;
  sius_stat_t stat;

  sius_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  sius_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_interval_low    (in_interval_low),
    .in_interval_high   (in_interval_high),
    .in_point           (in_point),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_covered        (out_covered),
    .out_interval_count (out_interval_count)
  );

endmodule
`default_nettype wire

FILE: rtl/sius_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sius_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sius_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/sius_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sius_ctrl
// Sequencer for the interval set: scan, resolve, copy/shift, place, finish.
// ----------------------------------------------------------------------------
module sius_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output sius_pkg::sius_cmd_t    cmd,
  input  wire sius_pkg::sius_stat_t stat
);
  import sius_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_RESOLVE = 6'b000100,
    S_COPY    = 6'b001000,
    S_PLACE   = 6'b010000,
    S_FINISH  = 6'b100000
  } sius_state_t;

  sius_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.needs_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        if (stat.is_query || (!stat.found && stat.full)) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_done) begin
          state_nxt = stat.found ? S_FINISH : S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/sius_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sius_dp
// Interval store datapath: entry RAM, scan/merge registers, copy engine.
// ----------------------------------------------------------------------------
module sius_dp #(
  parameter int MAX_INTERVALS = 16,
  parameter int COORD_WIDTH   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sius_pkg::sius_cmd_t               cmd,
  output sius_pkg::sius_stat_t                   stat,
  input  wire logic [sius_pkg::OP_W-1:0]         in_operation,
  input  wire logic signed [COORD_WIDTH-1:0]     in_interval_low,
  input  wire logic signed [COORD_WIDTH-1:0]     in_interval_high,
  input  wire logic signed [COORD_WIDTH-1:0]     in_point,
  output logic                                   out_valid,
  output logic [sius_pkg::STATUS_W-1:0]          out_status,
  output logic                                   out_covered,
  output logic [sius_pkg::COUNT_W-1:0]           out_interval_count
);
  import sius_pkg::*;

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int EW    = 2 * COORD_WIDTH;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

  // request registers
  logic [OP_W-1:0]               op_r, op_nxt;
  logic                          bad_r, bad_nxt;
  logic signed [COORD_WIDTH-1:0] lo_r, lo_nxt, hi_r, hi_nxt, pt_r, pt_nxt;
  // scan / merge state
  logic signed [COORD_WIDTH-1:0] mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic                          found_r, found_nxt, hit_r, hit_nxt, stop_r, stop_nxt;
  logic [CNT_W-1:0]              first_r, first_nxt, pos_r, pos_nxt, end_r, end_nxt;
  // read pipeline
  logic [CNT_W-1:0]              rd_ptr_r, rd_ptr_nxt, ridx_r, ridx_nxt;
  logic                          rvld_r, rvld_nxt, dir_r, dir_nxt;
  // store and result
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt, out_covered_r, out_covered_nxt;
  logic [STATUS_W-1:0]           out_status_r, out_status_nxt;

  logic                          range_bad, fwd_more, back_more, copy_more, rd_issue;
  logic                          is_add, full, ov;
  logic [CNT_W-1:0]              rd_idx, removed, ridx_p1, fwd_dst;
  logic [AW-1:0]                 rd_addr, waddr;
  logic                          we;
  logic [EW-1:0]                 wdata, rdata;
  logic signed [COORD_WIDTH-1:0] e_lo, e_hi;

  sius_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_INTERVALS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign e_lo      = $signed(rdata[EW-1:COORD_WIDTH]);
  assign e_hi      = $signed(rdata[COORD_WIDTH-1:0]);
  assign range_bad = (in_interval_high < in_interval_low);
  assign is_add    = (op_r == OP_ADD);
  assign full      = (cnt_r == CNT_MAX);
  assign removed   = end_r - first_r - 1'b1;
  assign ridx_p1   = ridx_r + 1'b1;
  assign fwd_dst   = ridx_r - removed;
  assign fwd_more  = (rd_ptr_r < cnt_r);
  assign back_more = (rd_ptr_r > pos_r);
  assign copy_more = dir_r ? back_more : fwd_more;
  // merged interval is tested, so it equals the request until a hit
  assign ov        = (e_lo <= mhi_r) && (e_hi >= mlo_r);

  always_comb begin
    stat.needs_scan = ((in_operation == OP_ADD) && !range_bad) || (in_operation == OP_QUERY);
    stat.is_query   = (op_r == OP_QUERY);
    stat.found      = found_r;
    stat.full       = full;
    stat.scan_done  = stop_r || (!fwd_more && !rvld_r);
    stat.copy_done  = !copy_more && !rvld_r;
  end

  // read issue
  always_comb begin
    rd_issue = 1'b0;
    if (cmd.scan) begin
      rd_issue = !stop_r && fwd_more;
    end else if (cmd.copy) begin
      rd_issue = copy_more;
    end
    // backward shift walks down from the top entry
    rd_idx  = (cmd.copy && dir_r) ? (rd_ptr_r - 1'b1) : rd_ptr_r;
    rd_addr = rd_idx[AW-1:0];
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd.resolve && found_r) begin
      we    = 1'b1;
      waddr = first_r[AW-1:0];
      wdata = {mlo_r, mhi_r};
    end else if (cmd.copy && rvld_r) begin
      we    = 1'b1;
      waddr = dir_r ? ridx_p1[AW-1:0] : fwd_dst[AW-1:0];
    end else if (cmd.place) begin
      we    = 1'b1;
      waddr = pos_r[AW-1:0];
      wdata = {lo_r, hi_r};
    end
  end

  always_comb begin
    op_nxt          = op_r;
    bad_nxt         = bad_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    pt_nxt          = pt_r;
    mlo_nxt         = mlo_r;
    mhi_nxt         = mhi_r;
    found_nxt       = found_r;
    hit_nxt         = hit_r;
    stop_nxt        = stop_r;
    first_nxt       = first_r;
    pos_nxt         = pos_r;
    end_nxt         = end_r;
    rd_ptr_nxt      = rd_ptr_r;
    ridx_nxt        = ridx_r;
    rvld_nxt        = rd_issue;
    dir_nxt         = dir_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = cmd.finish;
    out_status_nxt  = out_status_r;
    out_covered_nxt = out_covered_r;

    if (rd_issue) begin
      ridx_nxt   = rd_idx;
      rd_ptr_nxt = (cmd.copy && dir_r) ? (rd_ptr_r - 1'b1) : (rd_ptr_r + 1'b1);
    end

    if (cmd.load) begin
      op_nxt     = in_operation;
      bad_nxt    = (in_operation == OP_ADD) && range_bad;
      lo_nxt     = in_interval_low;
      hi_nxt     = in_interval_high;
      pt_nxt     = in_point;
      mlo_nxt    = in_interval_low;
      mhi_nxt    = in_interval_high;
      found_nxt  = 1'b0;
      hit_nxt    = 1'b0;
      stop_nxt   = 1'b0;
      first_nxt  = '0;
      pos_nxt    = '0;
      end_nxt    = '0;
      rd_ptr_nxt = '0;
    end

    if (cmd.scan && rvld_r && !stop_r) begin
      if (op_r == OP_QUERY) begin
        if ((e_lo <= pt_r) && (pt_r <= e_hi)) begin
          hit_nxt  = 1'b1;
          stop_nxt = 1'b1;
        end
      end else if (ov) begin
        found_nxt = 1'b1;
        if (!found_r) begin
          first_nxt = ridx_r;
        end
        if (e_lo < mlo_r) begin
          mlo_nxt = e_lo;
        end
        if (e_hi > mhi_r) begin
          mhi_nxt = e_hi;
        end
        end_nxt = ridx_r + 1'b1;
      end else if (found_r) begin
        stop_nxt = 1'b1;                 // merge run ended
      end else if (e_hi < lo_r) begin
        pos_nxt = ridx_r + 1'b1;
      end else begin
        stop_nxt = 1'b1;                 // entry lies above the request
      end
    end

    if (cmd.resolve) begin
      dir_nxt    = !found_r;
      rd_ptr_nxt = found_r ? end_r : cnt_r;
    end

    if (cmd.finish) begin
      out_covered_nxt = (op_r == OP_QUERY) && hit_r;
      out_status_nxt  = ST_DONE;
      if (bad_r) begin
        out_status_nxt = ST_INVALID;
      end else if (is_add && !found_r && full) begin
        out_status_nxt = ST_FULL;
      end
      if (op_r == OP_CLEAR) begin
        cnt_nxt = '0;
      end else if (is_add && !bad_r) begin
        if (found_r) begin
          cnt_nxt = cnt_r - removed;
        end else if (!full) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    bad_r         <= bad_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    pt_r          <= pt_nxt;
    mlo_r         <= mlo_nxt;
    mhi_r         <= mhi_nxt;
    found_r       <= found_nxt;
    hit_r         <= hit_nxt;
    stop_r        <= stop_nxt;
    first_r       <= first_nxt;
    pos_r         <= pos_nxt;
    end_r         <= end_nxt;
    rd_ptr_r      <= rd_ptr_nxt;
    ridx_r        <= ridx_nxt;
    dir_r         <= dir_nxt;
    out_status_r  <= out_status_nxt;
    out_covered_r <= out_covered_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_covered        = out_covered_r;
  assign out_interval_count = COUNT_W'(cnt_r);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("interval count above capacity");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (cnt_r == CNT_MAX))
    else $error("full status with free slots");

  a_copy_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.copy && rvld_r && rd_issue) |-> (waddr != rd_addr))
    else $error("copy writes the entry being read");

endmodule
`default_nettype wire
